// ===== hw/rtl/nbkd_pkg.sv =====
// nbkd_pkg: shared types and constants of the nine-bit keypad bus deframer
// no dependencies; imported by every module of the block but nbkd_ram

package nbkd_pkg;

   // bus word layout
   localparam int START_BIT = 8;
   localparam int BYTE_W    = 8;

   // most results one word may cause: characters plus the end beat
   localparam int MAX_RESULTS = 30;

   // result kinds
   localparam logic [1:0] KIND_IND  = 2'd0;
   localparam logic [1:0] KIND_CHAR = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // register indexes, taken from paddr[2]
   localparam logic REG_IND = 1'b0;
   localparam logic REG_TXT = 1'b1;

   // controller states
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_FETCH = 6'b000010,
      S_CHECK = 6'b000100,
      S_CHAR  = 6'b001000,
      S_END   = 6'b010000,
      S_IND   = 6'b100000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;     // word taken this cycle
      logic load_ind;   // load indicator result
      logic fetch;      // read stored text byte at walk index
      logic load_char;  // load character result from read data
      logic load_end;   // load end of text result
      logic advance;    // character beat delivered, step the walk
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ind_hit;    // incoming word closes a good indicator frame
      logic txt_hit;    // incoming word closes a good text frame
      logic more;       // walk index still inside text and result budget
      logic char_zero;  // fetched text byte is zero
   } ctrl_sts_type;

endpackage

// ===== hw/rtl/nbkd_ram.sv =====
// nbkd_ram: generic single write port, single read port RAM with registered read
// no dependencies

module nbkd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/nbkd_csr.sv =====
// nbkd_csr: apb register file holding the two command codes
// depends on nbkd_pkg

module nbkd_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [7:0]  ind_code,
   output logic [7:0]  txt_code
);

   import nbkd_pkg::*;

   logic [7:0] ind_code_ff, ind_code_in;
   logic [7:0] txt_code_ff, txt_code_in;
   logic       wr_en;

   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   // register write decode
   always_comb begin
      ind_code_in = ind_code_ff;
      txt_code_in = txt_code_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_IND: ind_code_in = pwdata[BYTE_W-1:0];
            REG_TXT: txt_code_in = pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ind_code_ff <= '0;
         txt_code_ff <= '0;
      end else begin
         ind_code_ff <= ind_code_in;
         txt_code_ff <= txt_code_in;
      end
   end

   // read mux
   always_comb begin
      case (paddr[2])
         REG_IND: prdata = {24'd0, ind_code_ff};
         REG_TXT: prdata = {24'd0, txt_code_ff};
         default: prdata = '0;
      endcase
   end

   assign ind_code = ind_code_ff;
   assign txt_code = txt_code_ff;

endmodule

// ===== hw/rtl/nbkd_datapath.sv =====
// nbkd_datapath: frame position, running checksum, frame store and result registers
// depends on nbkd_pkg and nbkd_ram

module nbkd_datapath #(
   parameter int FRAME_MAX = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            ind_code,
   input  logic [7:0]            txt_code,
   input  logic [8:0]            req_bus_word,
   input  nbkd_pkg::ctrl_cmd_type cmd,
   output nbkd_pkg::ctrl_sts_type sts,
   output logic [1:0]            rsp_result_kind,
   output logic [15:0]           rsp_indicator_bits,
   output logic [7:0]            rsp_text_char,
   output logic                  rsp_last_of_run
);

   import nbkd_pkg::*;

   localparam int PW = $clog2(FRAME_MAX + 1);
   localparam int AW = $clog2(FRAME_MAX);

   // frame state
   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    len_ff, len_in;     // byte at position 1: length or data byte 1
   logic [7:0]    b2_ff, b2_in;       // byte at position 2
   logic [7:0]    sum_ff, sum_in;
   // text walk
   logic [PW-1:0] idx_ff, idx_in;
   logic [PW-1:0] end_ff, end_in;
   // result registers
   logic [1:0]    kind_ff, kind_in;
   logic [15:0]   bits_ff, bits_in;
   logic [7:0]    char_ff, char_in;
   logic          last_ff, last_in;

   // word decode
   logic          start;
   logic [7:0]    byte_w;
   logic          active;
   logic          is_ind;
   logic          is_txt;
   logic [9:0]    end_w;
   logic [9:0]    pos_w;
   logic          ind_store;
   logic          ind_chk;
   logic          txt_store;
   logic          txt_chk;
   logic          do_store;
   logic [7:0]    rd_data;

   always_comb begin
      start     = req_bus_word[START_BIT];
      byte_w    = req_bus_word[BYTE_W-1:0];
      active    = !start && (pos_ff < PW'(FRAME_MAX));
      is_ind    = (cmd_ff == ind_code);
      is_txt    = !is_ind && (cmd_ff == txt_code);
      end_w     = {2'b00, len_ff} + 10'd2;
      pos_w     = 10'(pos_ff);
      ind_store = active && is_ind && (pos_ff < PW'(3));
      ind_chk   = active && is_ind && (pos_ff == PW'(3));
      txt_store = active && is_txt && ((pos_ff == PW'(1)) || (pos_w < end_w));
      txt_chk   = active && is_txt && !txt_store && (pos_w == end_w);
      do_store  = ind_store || txt_store;
   end

   // status to controller
   always_comb begin
      sts.ind_hit   = ind_chk && (sum_ff == byte_w);
      sts.txt_hit   = txt_chk && (sum_ff == byte_w);
      sts.more      = (idx_ff < end_ff) && (32'(idx_ff) < 32'(MAX_RESULTS + 1));
      sts.char_zero = (rd_data == 8'd0);
   end

   // frame tracking on each accepted word
   always_comb begin
      pos_in = pos_ff;
      cmd_in = cmd_ff;
      len_in = len_ff;
      b2_in  = b2_ff;
      sum_in = sum_ff;
      if (cmd.accept) begin
         if (start) begin
            cmd_in = byte_w;
            sum_in = byte_w;
            pos_in = PW'(1);
         end else if (do_store) begin
            sum_in = sum_ff + byte_w;
            pos_in = pos_ff + PW'(1);
            if (pos_ff == PW'(1)) begin
               len_in = byte_w;
            end
            if (pos_ff == PW'(2)) begin
               b2_in = byte_w;
            end
         end else if (ind_chk || txt_chk) begin
            pos_in = pos_ff + PW'(1);
         end
      end
   end

   // text walk index
   always_comb begin
      idx_in = idx_ff;
      end_in = end_ff;
      if (cmd.accept && sts.txt_hit) begin
         idx_in = PW'(2);
         end_in = pos_ff;
      end else if (cmd.advance) begin
         idx_in = idx_ff + PW'(1);
      end
   end

   // result register loads
   always_comb begin
      kind_in = kind_ff;
      bits_in = bits_ff;
      char_in = char_ff;
      last_in = last_ff;
      if (cmd.load_ind) begin
         kind_in = KIND_IND;
         bits_in = {b2_ff, len_ff};
         char_in = '0;
         last_in = 1'b1;
      end else if (cmd.load_char) begin
         kind_in = KIND_CHAR;
         bits_in = '0;
         char_in = rd_data;
         last_in = 1'b0;
      end else if (cmd.load_end) begin
         kind_in = KIND_END;
         bits_in = '0;
         char_in = '0;
         last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= PW'(FRAME_MAX);
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      len_ff  <= len_in;
      b2_ff   <= b2_in;
      sum_ff  <= sum_in;
      idx_ff  <= idx_in;
      end_ff  <= end_in;
      kind_ff <= kind_in;
      bits_ff <= bits_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   // frame store
   nbkd_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.accept && do_store),
      .wr_addr (pos_ff[AW-1:0]),
      .wr_data (byte_w),
      .rd_en   (cmd.fetch),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_result_kind    = kind_ff;
   assign rsp_indicator_bits = bits_ff;
   assign rsp_text_char      = char_ff;
   assign rsp_last_of_run    = last_ff;

endmodule

// ===== hw/rtl/nbkd_ctrl.sv =====
// nbkd_ctrl: state machine sequencing word intake and result beats
// depends on nbkd_pkg

module nbkd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  nbkd_pkg::ctrl_sts_type sts,
   output nbkd_pkg::ctrl_cmd_type cmd
);

   import nbkd_pkg::*;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.ind_hit) begin
                  cmd.load_ind = 1'b1;
                  state_in     = S_IND;
               end else if (sts.txt_hit) begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            if (sts.more) begin
               cmd.fetch = 1'b1;
               state_in  = S_CHECK;
            end else begin
               cmd.load_end = 1'b1;
               state_in     = S_END;
            end
         end
         S_CHECK: begin
            if (sts.char_zero) begin
               cmd.load_end = 1'b1;
               state_in     = S_END;
            end else begin
               cmd.load_char = 1'b1;
               state_in      = S_CHAR;
            end
         end
         S_CHAR: begin
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               state_in    = S_FETCH;
            end
         end
         S_END, S_IND: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = state_ff inside {S_CHAR, S_END, S_IND};

endmodule

// ===== hw/rtl/nine_bit_keypad_bus_deframer_top.sv =====
// nine_bit_keypad_bus_deframer_top: top level of the keypad bus deframer
// depends on nbkd_pkg, nbkd_csr, nbkd_ctrl, nbkd_datapath and nbkd_ram

// A 9-bit bus word from which no result follows leaves the block idle and
// ready for the next word. A word that closes an indicator frame with a good
// checksum gives one beat, then the block takes words again. A word that
// closes a text frame with a good checksum starts a walk over the frame store
// RAM: each character passes through an address state, a registered read and
// a result beat, and the end of text beat follows an end of walk decision, or
// a fetch and a zero check when the walk stops on a zero byte. No further
// word is taken until the last beat of a frame is delivered. The frame store
// has no clearing pass; the block is ready right after reset. Command codes
// are written over the APB port at byte addresses 0 (indicator) and 4 (text)
// while the block is idle.

module nine_bit_keypad_bus_deframer_top #(
   parameter int FRAME_MAX = 32
) (
   input  logic        clock,
   input  logic        reset,
   // word input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [8:0]  req_bus_word,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_indicator_bits,
   output logic [7:0]  rsp_text_char,
   output logic        rsp_last_of_run,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   import nbkd_pkg::*;

   logic [7:0]   ind_code;
   logic [7:0]   txt_code;
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // command code registers
   nbkd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .ind_code (ind_code),
      .txt_code (txt_code)
   );

   // sequencing
   nbkd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // framing and result data
   nbkd_datapath #(
      .FRAME_MAX (FRAME_MAX)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ind_code           (ind_code),
      .txt_code           (txt_code),
      .req_bus_word       (req_bus_word),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_indicator_bits (rsp_indicator_bits),
      .rsp_text_char      (rsp_text_char),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

// ===== hw/rtl/nbkd_checker.sv =====
// nbkd_checker: port level checks of the keypad bus deframer, bound to the top level
// depends on nbkd_pkg and nine_bit_keypad_bus_deframer_top

module nbkd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_result_kind,
   input logic [15:0] rsp_indicator_bits,
   input logic [7:0]  rsp_text_char,
   input logic        rsp_last_of_run
);

   import nbkd_pkg::*;

   // no beat pending right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat pending after reset");

   // a stalled beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_indicator_bits) && $stable(rsp_text_char)
         && $stable(rsp_last_of_run))
      else $error("stalled result beat changed");

   // no word is taken while a result beat waits
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("word input open while result pending");

   // character beats are never last and carry a nonzero byte
   a_char_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_CHAR) |->
         !rsp_last_of_run && (rsp_indicator_bits == 16'd0) && (rsp_text_char != 8'd0))
      else $error("malformed character beat");

   // indicator and end beats close the run
   a_last_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_result_kind == KIND_IND) || (rsp_result_kind == KIND_END))
         |-> rsp_last_of_run)
      else $error("closing beat not marked last");

endmodule

bind nine_bit_keypad_bus_deframer_top nbkd_checker u_checker (.*);
